>>> src/well512_random_generator_macros.svh
// Assertion macros shared by the well512 generator RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef WELL512_RANDOM_GENERATOR_MACROS_SVH
`define WELL512_RANDOM_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define W512_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("w512 assertion failed");

`define W512_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("w512 assertion failed");

`else

`define W512_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define W512_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/w512_pkg.sv
// Package for the well512 generator: constants, types and mixing helpers.
// No dependencies.
`default_nettype none

package w512_pkg;

  localparam int unsigned POOL_DEPTH = 16;
  localparam int unsigned IDX_W      = $clog2(POOL_DEPTH);

  typedef logic [31:0]      word_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam word_t SEED_MULT   = 32'd1812433253;
  localparam word_t TEMPER_MASK = 32'hDA44_2D24;

  localparam idx_t OFF_M1 = idx_t'(13);
  localparam idx_t OFF_M2 = idx_t'(9);
  localparam idx_t OFF_PREV = idx_t'(15);

  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_RESEED   = 1'b1;

  function automatic word_t mix_first(input word_t a, input word_t c);
    mix_first = a ^ c ^ (a << 16) ^ (c << 15);
  endfunction

endpackage

`default_nettype wire

>>> src/w512_mix.sv
// Second half of one WELL512a step: new word at the index and the output word.
// Depends on w512_pkg.
`default_nettype none

module w512_mix (
  input  w512_pkg::word_t b_i,
  input  w512_pkg::word_t m2_i,
  input  w512_pkg::word_t prev_i,
  output w512_pkg::word_t new_k_o,
  output w512_pkg::word_t new_prev_o
);
  import w512_pkg::*;

  word_t c;
  word_t a;
  word_t d;

  always_comb begin
    c          = m2_i ^ (m2_i >> 11);
    a          = b_i ^ c;
    d          = a ^ ((a << 5) & TEMPER_MASK);
    new_k_o    = a;
    new_prev_o = prev_i ^ b_i ^ d ^ (prev_i << 2) ^ (b_i << 18) ^ (c << 28);
  end

endmodule

`default_nettype wire

>>> src/well512_random_generator.sv
// Top level of the WELL512a generator: pool memory, sequencer and seeding.
// Depends on w512_pkg, w512_mix and well512_random_generator_macros.svh.
`default_nettype none
`include "well512_random_generator_macros.svh"

// A transaction is taken when start is high and busy is low. A generate
// transaction keeps busy high through states RD2, WR1 and WR2: the 16-word
// pool sits in one memory with two registered read ports and one write port,
// so the four reads are issued in IDLE and RD2 and the two write-backs in
// WR1 and WR2, the first write overlapping the second read's use. Its word
// is on out_random_word for exactly one cycle with out_valid high, in WR2,
// the last busy cycle; the receiver cannot stall it. A reseed transaction
// writes word 0 at the accepting edge and then keeps busy high in state
// SEED while it writes pool words 1 to 15, one pool word per cycle through
// the seeding multiplier, and gives no result. Generate only after a reseed.
module well512_random_generator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_operation,
  input  w512_pkg::word_t      in_seed_value,
  output logic                 out_valid,
  output w512_pkg::word_t      out_random_word
);
  import w512_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD2,
    ST_WR1,
    ST_WR2,
    ST_SEED
  } state_t;

  state_t state_r, state_nxt;
  idx_t   idx_r, idx_nxt;
  idx_t   cnt_r, cnt_nxt;
  word_t  seed_r, seed_nxt;
  word_t  b_r, b_nxt;
  word_t  wprev_r, wprev_nxt;
  logic   out_valid_r, out_valid_nxt;
  word_t  out_word_r, out_word_nxt;

  word_t  pool_mem [POOL_DEPTH];
  word_t  rd0_r, rd1_r;
  idx_t   raddr0, raddr1, waddr;
  word_t  wdata;
  logic   we;

  word_t  new_k, new_prev, seed_prod;
  logic   accept;

  assign accept    = start && (state_r == ST_IDLE);
  assign seed_prod = SEED_MULT * (seed_r ^ (seed_r >> 30));

  w512_mix u_mix (
    .b_i       (b_r),
    .m2_i      (rd0_r),
    .prev_i    (rd1_r),
    .new_k_o   (new_k),
    .new_prev_o(new_prev)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    seed_nxt      = seed_r;
    b_nxt         = b_r;
    wprev_nxt     = wprev_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    raddr0        = idx_r;
    raddr1        = idx_t'(idx_r + OFF_M1);
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = new_k;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_RESEED) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = in_seed_value;
            seed_nxt  = in_seed_value;
            cnt_nxt   = idx_t'(1);
            state_nxt = ST_SEED;
          end else begin
            state_nxt = ST_RD2;
          end
        end
      end
      ST_RD2: begin
        b_nxt     = mix_first(rd0_r, rd1_r);
        raddr0    = idx_t'(idx_r + OFF_M2);
        raddr1    = idx_t'(idx_r + OFF_PREV);
        state_nxt = ST_WR1;
      end
      ST_WR1: begin
        we            = 1'b1;
        waddr         = idx_r;
        wdata         = new_k;
        wprev_nxt     = new_prev;
        out_word_nxt  = new_prev;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_WR2;
      end
      ST_WR2: begin
        we        = 1'b1;
        waddr     = idx_t'(idx_r + OFF_PREV);
        wdata     = wprev_r;
        idx_nxt   = idx_t'(idx_r + OFF_PREV);
        state_nxt = ST_IDLE;
      end
      ST_SEED: begin
        we        = 1'b1;
        waddr     = cnt_r;
        wdata     = seed_prod + word_t'(cnt_r);
        seed_nxt  = seed_prod + word_t'(cnt_r);
        cnt_nxt   = idx_t'(cnt_r + idx_t'(1));
        if (cnt_r == idx_t'(POOL_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    seed_r     <= seed_nxt;
    b_r        <= b_nxt;
    wprev_r    <= wprev_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      pool_mem[waddr] <= wdata;
    end
    rd0_r <= pool_mem[raddr0];
    rd1_r <= pool_mem[raddr1];
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  `W512_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_valid, busy)
  `W512_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `W512_ASSERT_NXT(a_gen_goes_busy, clk, rst_n,
                   start && !busy && (in_operation == OP_GENERATE), busy && !out_valid)
  `W512_ASSERT_NXT(a_seed_ends, clk, rst_n,
                   (state_r == ST_SEED) && (cnt_r == idx_t'(POOL_DEPTH - 1)), !busy)
  `W512_ASSERT_NXT(a_idx_steady_seed, clk, rst_n, state_r == ST_SEED, $stable(idx_r))

endmodule

`default_nettype wire

>>> sim/tb_well512_random_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for well512_random_generator: directed and random
// reseed/generate transactions checked against an in-bench WELL512a pool model.
// Depends on w512_pkg and the well512_random_generator RTL.

module tb_well512_random_generator;
  import w512_pkg::*;

  localparam int unsigned STALL_LIMIT  = 400;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned DRAIN_CYCLES = 24;

  class well512_word_tracker;
    word_t       pool [POOL_DEPTH];
    idx_t        pool_idx;
    word_t       expected_words [$];
    int unsigned mismatch_count;
    int unsigned words_checked;
    int unsigned reseed_count;
    int unsigned generate_count;

    function new();
      foreach (pool[i]) pool[i] = '0;
      pool_idx       = '0;
      mismatch_count = 0;
      words_checked  = 0;
      reseed_count   = 0;
      generate_count = 0;
    endfunction

    function void reseed(word_t seed);
      word_t p;
      pool[0] = seed;
      for (int unsigned i = 1; i < POOL_DEPTH; i++) begin
        p       = pool[i-1];
        pool[i] = SEED_MULT * (p ^ (p >> 30)) + word_t'(i);
      end
    endfunction

    function word_t next_word();
      word_t a, b, c, d;
      idx_t  k, k_m1, k_m2;
      k    = pool_idx;
      k_m1 = k + OFF_M1;
      k_m2 = k + OFF_M2;
      a = pool[k];
      c = pool[k_m1];
      b = a ^ c ^ (a << 16) ^ (c << 15);
      c = pool[k_m2];
      c = c ^ (c >> 11);
      a = b ^ c;
      pool[k] = a;
      d = a ^ ((a << 5) & TEMPER_MASK);
      k = k + OFF_PREV;
      pool_idx = k;
      a = pool[k];
      pool[k] = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
      return pool[k];
    endfunction

    // called at the edge where a transaction is accepted
    function void note_transaction(logic op, word_t seed);
      if (op == OP_RESEED) begin
        reseed(seed);
        reseed_count++;
      end else begin
        expected_words.push_back(next_word());
        generate_count++;
      end
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_word(word_t got);
      word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word %h", got));
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (got !== want)
          report($sformatf("random_word got %h expected %h", got, want));
      end
    endtask

    task check_drained();
      if (expected_words.size() != 0)
        report($sformatf("%0d expected words never arrived", expected_words.size()));
    endtask
  endclass

  logic  clk           = 1'b0;
  logic  rst_n         = 1'b0;
  logic  start         = 1'b0;
  logic  in_operation  = OP_GENERATE;
  word_t in_seed_value = '0;
  logic  busy;
  logic  out_valid;
  word_t out_random_word;

  well512_word_tracker tracker = new();
  bit          idle_enable = 1'b1;
  int unsigned stall_cycles = 0;

  always #2 clk = ~clk;

  well512_random_generator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_random_word (out_random_word)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_word(out_random_word);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, stall_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // returns at the edge where the transaction is accepted
  task send(logic op, word_t seed);
    if (idle_enable && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_seed_value <= seed;
    do @(posedge clk); while (busy);
    tracker.note_transaction(op, seed);
  endtask

  task send_generates(int unsigned n);
    repeat (n) send(OP_GENERATE, $urandom());
  endtask

  initial begin
    word_t seed;
    logic  op;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: seed extremes, reseed mid-stream, back-to-back reseeds
    send(OP_RESEED, 32'h0000_0000);
    send(OP_GENERATE, 32'hFFFF_FFFF);
    send(OP_GENERATE, 32'h0000_0000);
    send_generates(1);
    send(OP_RESEED, 32'hFFFF_FFFF);
    send_generates(4);
    send(OP_RESEED, 32'h8000_0000);
    send_generates(2);
    send(OP_RESEED, 32'h0000_0001);
    send_generates(2);
    send(OP_RESEED, 32'hAAAA_AAAA);
    send(OP_RESEED, 32'h5555_5555);
    send_generates(3);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      idle_enable = !(n >= 300 && n < 450);
      op   = ($urandom_range(24) == 0) ? OP_RESEED : OP_GENERATE;
      seed = $urandom();
      case ($urandom_range(15))
        0: seed = 32'h0000_0000;
        1: seed = 32'hFFFF_FFFF;
        default: ;
      endcase
      send(op, seed);
    end
    start <= 1'b0;

    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.check_drained();

    $display("covered %0d generate and %0d reseed transactions, %0d words checked",
             tracker.generate_count, tracker.reseed_count, tracker.words_checked);
    if (tracker.mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
